// ===== rtl/core/epdc_pkg.sv =====
// Shared types, calendar tables and the microcode program for the epoch day converter.
// No dependencies; used by epdc_useq, epoch_day_date_converter_unit, epdc_tb_pkg and tb.
package epdc_pkg;

    // field widths
    localparam int DAYS_W   = 16;
    localparam int YEAR_W   = 8;
    localparam int MONTH_W  = 4;
    localparam int MDAY_W   = 5;
    localparam int WDAY_W   = 3;
    localparam int YLEN_W   = 9;
    localparam int PC_W     = 4;

    // calendar constants, years counted from 1900
    localparam logic [YEAR_W-1:0]  EPOCH_YEAR   = 8'd70;
    localparam logic [YEAR_W-1:0]  YEAR_MIN     = 8'd70;
    localparam logic [YEAR_W-1:0]  YEAR_MAX     = 8'd199;
    localparam logic [YEAR_W-1:0]  CENTURY_1900 = 8'd0;
    localparam logic [YEAR_W-1:0]  CENTURY_2100 = 8'd200;
    localparam logic [MONTH_W-1:0] MONTH_SAT    = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_LAST   = 4'd11;
    localparam logic [WDAY_W-1:0]  EPOCH_WDAY   = 3'd4;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD_ZERO,
        OP_LOAD_DAYS,
        OP_ADD_YEAR,
        OP_ADD_DBM,
        OP_ADD_MDAY,
        OP_SUB_YEAR,
        OP_SUB_MONTH
    } op_t;

    // finish is kept apart so the sequencer can spot it
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_FUNC,
        COND_RANGE_ERR,
        COND_YEAR_DONE,
        COND_REM_LT_YEAR,
        COND_MONTH_DONE
    } cond_t;

    // jump: run op, then branch on cond; loop: stay and run op until cond holds
    typedef enum logic [1:0] {
        MODE_JUMP,
        MODE_LOOP,
        MODE_FINISH
    } mode_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        mode_t           mode;
        logic [PC_W-1:0] target;
    } ctrl_t;

    // status flags from the datapath to the sequencer
    typedef struct packed {
        logic func;
        logic range_err;
        logic year_done;
        logic rem_lt_year;
        logic month_done;
    } cond_flags_t;

    // datapath command from the sequencer
    typedef struct packed {
        op_t  op;
        logic exec;
        logic finish;
    } dp_ctrl_t;

    // program addresses
    localparam logic [PC_W-1:0] PC_ENTRY     = 4'd0;
    localparam logic [PC_W-1:0] PC_TO_DATE   = 4'd6;
    localparam logic [PC_W-1:0] PC_FINISH    = 4'd9;

    // gregorian leap rule on years since 1900 (1900 % 4 == 0)
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        return (y[1:0] == 2'd0) && (y != CENTURY_1900) && (y != CENTURY_2100);
    endfunction

    function automatic logic [YLEN_W-1:0] year_len(input logic [YEAR_W-1:0] y);
        return 9'd365 + {8'd0, is_leap(y)};
    endfunction

    function automatic logic [MDAY_W-1:0] month_len(input logic leap,
                                                     input logic [MONTH_W-1:0] m);
        logic [MDAY_W-1:0] len;
        unique case (m)
            4'd1:                      len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // days in the months before m, month codes above twelve saturate
    function automatic logic [YLEN_W-1:0] days_before(input logic leap,
                                                      input logic [MONTH_W-1:0] m);
        logic [MONTH_W-1:0] ms;
        logic [YLEN_W-1:0]  base;
        ms = (m > MONTH_SAT) ? MONTH_SAT : m;
        unique case (ms)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd365;
        endcase
        return base + {8'd0, (leap && (ms >= 4'd2))};
    endfunction

    // x mod 7 by folding octal digits, since 8 is 1 mod 7
    function automatic logic [WDAY_W-1:0] mod7(input logic [DAYS_W:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] r;
        s1 = {3'd0, x[2:0]} + {3'd0, x[5:3]} + {3'd0, x[8:6]}
           + {3'd0, x[11:9]} + {3'd0, x[14:12]} + {4'd0, x[16:15]};
        s2 = {1'b0, s1[2:0]} + {1'b0, s1[5:3]};
        r  = (s2 >= 4'd7) ? s2 - 4'd7 : s2;
        r  = (r >= 4'd7) ? r - 4'd7 : r;
        return r[WDAY_W-1:0];
    endfunction

    // microcode program
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        unique case (pc)
            // dispatch on direction, then finish early on a range error
            4'd0:    w = '{OP_NOP,       COND_FUNC,        MODE_JUMP,   PC_TO_DATE};
            4'd1:    w = '{OP_NOP,       COND_RANGE_ERR,   MODE_JUMP,   PC_FINISH};
            // date to days
            4'd2:    w = '{OP_LOAD_ZERO, COND_NEVER,       MODE_JUMP,   PC_ENTRY};
            4'd3:    w = '{OP_ADD_YEAR,  COND_YEAR_DONE,   MODE_LOOP,   PC_ENTRY};
            4'd4:    w = '{OP_ADD_DBM,   COND_NEVER,       MODE_JUMP,   PC_ENTRY};
            4'd5:    w = '{OP_ADD_MDAY,  COND_ALWAYS,      MODE_JUMP,   PC_FINISH};
            // days to date
            4'd6:    w = '{OP_LOAD_DAYS, COND_NEVER,       MODE_JUMP,   PC_ENTRY};
            4'd7:    w = '{OP_SUB_YEAR,  COND_REM_LT_YEAR, MODE_LOOP,   PC_ENTRY};
            4'd8:    w = '{OP_SUB_MONTH, COND_MONTH_DONE,  MODE_LOOP,   PC_ENTRY};
            4'd9:    w = '{OP_NOP,       COND_NEVER,       MODE_FINISH, PC_ENTRY};
            default: w = '{OP_NOP,       COND_NEVER,       MODE_FINISH, PC_ENTRY};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/epdc_useq.sv =====
// Microcode sequencer: step counter, program table and conditional branching.
// Depends on epdc_pkg for the control word, flag and command types.
module epdc_useq
    import epdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        hold,
    input  cond_flags_t flags,
    output logic        busy,
    output dp_ctrl_t    dp
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            busy_reg;
    logic            busy_next;
    ctrl_t           word;
    logic            cond_true;
    logic            advance;

    // fetch and condition select
    always_comb
    begin
        word = ucode(pc_reg);
        unique case (word.cond)
            COND_NEVER:       cond_true = 1'b0;
            COND_ALWAYS:      cond_true = 1'b1;
            COND_FUNC:        cond_true = flags.func;
            COND_RANGE_ERR:   cond_true = flags.range_err;
            COND_YEAR_DONE:   cond_true = flags.year_done;
            COND_REM_LT_YEAR: cond_true = flags.rem_lt_year;
            COND_MONTH_DONE:  cond_true = flags.month_done;
            default:          cond_true = 1'b0;
        endcase
    end

    // finish waits while the output register is full and stalled
    assign advance   = busy_reg && !((word.mode == MODE_FINISH) && hold);
    assign dp.op     = word.op;
    assign dp.finish = advance && (word.mode == MODE_FINISH);
    assign dp.exec   = advance && ((word.mode == MODE_JUMP) ||
                                   ((word.mode == MODE_LOOP) && !cond_true));
    assign busy      = busy_reg;

    // next step
    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (start)
        begin
            pc_next   = PC_ENTRY;
            busy_next = 1'b1;
        end
        else if (advance)
        begin
            unique case (word.mode)
                MODE_JUMP:   pc_next = cond_true ? word.target : pc_reg + 1'b1;
                MODE_LOOP:   pc_next = cond_true ? pc_reg + 1'b1 : pc_reg;
                MODE_FINISH: busy_next = 1'b0;
                default:     pc_next = pc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= PC_ENTRY;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// ===== rtl/core/epoch_day_date_converter_unit.sv =====
// Epoch day / Gregorian date converter: microcoded sequencer over a 16-bit accumulator.
// Date to days runs one accumulator loop step per year since 1970 and skips to the finish
// on an out-of-range year; days to date runs one step per year and then one per month.
// One item in flight: the next item is taken the cycle after the result is registered,
// and a finished item waits in the sequencer while the output register is full and stalled.
// Reset clears the sequencer and the output valid; payload registers are not reset.
module epoch_day_date_converter_unit
    import epdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // input item
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic [YEAR_W-1:0]  year_since_1900,
    input  logic [MONTH_W-1:0] month_index,
    input  logic [MDAY_W-1:0]  day_of_month,
    input  logic [DAYS_W-1:0]  day_count_in,
    // result item
    output logic               out_valid,
    input  logic               out_stall,
    output logic [DAYS_W-1:0]  day_count_out,
    output logic [YEAR_W-1:0]  year_out,
    output logic [MONTH_W-1:0] month_out,
    output logic [MDAY_W-1:0]  mday_out,
    output logic [WDAY_W-1:0]  weekday_out,
    output logic               range_error
);

    logic               busy;
    logic               start;
    logic               hold;
    cond_flags_t        flags;
    dp_ctrl_t           dp;

    // captured item
    logic               func_reg;
    logic [YEAR_W-1:0]  year_in_reg;
    logic [MONTH_W-1:0] month_in_reg;
    logic [MDAY_W-1:0]  mday_in_reg;
    logic [DAYS_W-1:0]  days_in_reg;

    // working registers
    logic [DAYS_W-1:0]  acc_reg;
    logic [YEAR_W-1:0]  y_reg;
    logic [MONTH_W-1:0] m_reg;

    // output register
    logic               out_valid_reg;
    logic [DAYS_W-1:0]  day_count_out_reg;
    logic [YEAR_W-1:0]  year_out_reg;
    logic [MONTH_W-1:0] month_out_reg;
    logic [MDAY_W-1:0]  mday_out_reg;
    logic [WDAY_W-1:0]  weekday_out_reg;
    logic               range_error_reg;

    logic [YLEN_W-1:0]  cur_year_len;
    logic [MDAY_W-1:0]  cur_month_len;
    logic               in_range_err;

    assign start    = in_valid && !busy;
    assign in_stall = busy;
    assign hold     = out_valid_reg && out_stall;

    // status flags
    assign cur_year_len      = year_len(y_reg);
    assign cur_month_len     = month_len(is_leap(y_reg), m_reg);
    assign in_range_err      = (year_in_reg < YEAR_MIN) || (year_in_reg > YEAR_MAX);
    assign flags.func        = func_reg;
    assign flags.range_err   = in_range_err;
    assign flags.year_done   = (y_reg == year_in_reg);
    assign flags.rem_lt_year = (acc_reg < {{(DAYS_W-YLEN_W){1'b0}}, cur_year_len});
    assign flags.month_done  = (m_reg == MONTH_LAST) ||
                               (acc_reg < {{(DAYS_W-MDAY_W){1'b0}}, cur_month_len});

    epdc_useq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .hold  (hold),
        .flags (flags),
        .busy  (busy),
        .dp    (dp)
    );

    // item capture
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            func_reg     <= func;
            year_in_reg  <= year_since_1900;
            month_in_reg <= month_index;
            mday_in_reg  <= day_of_month;
            days_in_reg  <= day_count_in;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (dp.exec)
        begin
            unique case (dp.op)
                OP_NOP:
                begin
                end
                OP_LOAD_ZERO:
                begin
                    acc_reg <= '0;
                    y_reg   <= EPOCH_YEAR;
                end
                OP_LOAD_DAYS:
                begin
                    acc_reg <= days_in_reg;
                    y_reg   <= EPOCH_YEAR;
                    m_reg   <= '0;
                end
                OP_ADD_YEAR:
                begin
                    acc_reg <= acc_reg + {{(DAYS_W-YLEN_W){1'b0}}, cur_year_len};
                    y_reg   <= y_reg + 1'b1;
                end
                OP_ADD_DBM:
                begin
                    acc_reg <= acc_reg + {{(DAYS_W-YLEN_W){1'b0}},
                                          days_before(is_leap(year_in_reg), month_in_reg)};
                end
                OP_ADD_MDAY:
                begin
                    acc_reg <= acc_reg + {{(DAYS_W-MDAY_W){1'b0}}, mday_in_reg}
                               - {{(DAYS_W-1){1'b0}}, 1'b1};
                end
                OP_SUB_YEAR:
                begin
                    acc_reg <= acc_reg - {{(DAYS_W-YLEN_W){1'b0}}, cur_year_len};
                    y_reg   <= y_reg + 1'b1;
                end
                OP_SUB_MONTH:
                begin
                    acc_reg <= acc_reg - {{(DAYS_W-MDAY_W){1'b0}}, cur_month_len};
                    m_reg   <= m_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (dp.finish)
        begin
            if (func_reg)
            begin
                day_count_out_reg <= '0;
                range_error_reg   <= 1'b0;
                year_out_reg      <= y_reg;
                month_out_reg     <= m_reg;
                mday_out_reg      <= acc_reg[MDAY_W-1:0] + 1'b1;
                weekday_out_reg   <= mod7({1'b0, days_in_reg}
                                          + {{(DAYS_W+1-WDAY_W){1'b0}}, EPOCH_WDAY});
            end
            else
            begin
                day_count_out_reg <= in_range_err ? '0 : acc_reg;
                range_error_reg   <= in_range_err;
                year_out_reg      <= '0;
                month_out_reg     <= '0;
                mday_out_reg      <= '0;
                weekday_out_reg   <= '0;
            end
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dp.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign day_count_out = day_count_out_reg;
    assign year_out      = year_out_reg;
    assign month_out     = month_out_reg;
    assign mday_out      = mday_out_reg;
    assign weekday_out   = weekday_out_reg;
    assign range_error   = range_error_reg;

endmodule

// ===== tb/epdc_tb_pkg.sv =====
`timescale 1ns / 1ps
// Conversion item types and the result scoreboard for the epoch day converter bench.
// Depends on epdc_pkg for the field widths; used by tb.
package epdc_tb_pkg;

    import epdc_pkg::*;

    // direction select codes
    localparam logic FUNC_TO_DAYS = 1'b0;
    localparam logic FUNC_TO_DATE = 1'b1;

    // calendar constants, in full years or counted from 1900
    localparam int unsigned FIRST_FULL_YEAR  = 1970;
    localparam int unsigned CENTURY_BASE     = 1900;
    localparam int unsigned LOWEST_YEAR      = 70;
    localparam int unsigned HIGHEST_YEAR     = 199;
    localparam int unsigned MONTHS_IN_YEAR   = 12;
    localparam int unsigned WEEKDAY_AT_EPOCH = 4;
    localparam int unsigned DAYS_IN_WEEK     = 7;

    typedef struct packed {
        logic               func;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [MDAY_W-1:0]  mday;
        logic [DAYS_W-1:0]  days;
    } date_request_t;

    typedef struct packed {
        logic [DAYS_W-1:0]  days;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [MDAY_W-1:0]  mday;
        logic [WDAY_W-1:0]  wday;
        logic               range_err;
    } date_result_t;

    class calendar_scoreboard;

        date_result_t pending_dates[$];
        int unsigned  errors;
        int unsigned  checked;
        int unsigned  to_days;
        int unsigned  to_date;
        int unsigned  bad_years;

        function new();
            errors    = 0;
            checked   = 0;
            to_days   = 0;
            to_date   = 0;
            bad_years = 0;
        endfunction

        // gregorian rule on full years
        static function bit is_leap_year(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        static function int unsigned days_in_month(bit lp, int unsigned m);
            case (m)
                1:       return lp ? 29 : 28;
                3, 5, 8, 10: return 30;
                default: return 31;
            endcase
        endfunction

        // expected result of one conversion
        function date_result_t predict_conversion(date_request_t rq);
            date_result_t res;
            int unsigned  total;
            int unsigned  full;
            int unsigned  mon;
            int unsigned  rem;
            int unsigned  y;
            int unsigned  m;
            bit           lp;
            res = '0;
            if (rq.func == FUNC_TO_DAYS) begin
                if (rq.year < LOWEST_YEAR || rq.year > HIGHEST_YEAR) begin
                    res.range_err = 1'b1;
                end
                else begin
                    full  = CENTURY_BASE + rq.year;
                    total = 0;
                    for (y = FIRST_FULL_YEAR; y < full; y++)
                        total += 365 + is_leap_year(y);
                    // month codes past the year saturate to the whole year
                    mon = (rq.month > MONTHS_IN_YEAR) ? MONTHS_IN_YEAR : rq.month;
                    lp  = is_leap_year(full);
                    for (m = 0; m < mon; m++)
                        total += days_in_month(lp, m);
                    // day zero wraps below zero
                    total    = total + rq.mday - 1;
                    res.days = total[DAYS_W-1:0];
                end
            end
            else begin
                rem = rq.days;
                y   = FIRST_FULL_YEAR;
                while (rem >= 365 + is_leap_year(y)) begin
                    rem -= 365 + is_leap_year(y);
                    y++;
                end
                lp = is_leap_year(y);
                m  = 0;
                while (m < MONTHS_IN_YEAR - 1 && rem >= days_in_month(lp, m)) begin
                    rem -= days_in_month(lp, m);
                    m++;
                end
                res.year  = YEAR_W'(y - CENTURY_BASE);
                res.month = MONTH_W'(m);
                res.mday  = MDAY_W'(rem + 1);
                res.wday  = WDAY_W'((rq.days + WEEKDAY_AT_EPOCH) % DAYS_IN_WEEK);
            end
            return res;
        endfunction

        function void note_request(date_request_t rq);
            if (rq.func == FUNC_TO_DAYS) begin
                to_days++;
                if (rq.year < LOWEST_YEAR || rq.year > HIGHEST_YEAR)
                    bad_years++;
            end
            else begin
                to_date++;
            end
            pending_dates.push_back(predict_conversion(rq));
        endfunction

        function void compare_field(string name, logic [DAYS_W-1:0] want,
                                    logic [DAYS_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(date_result_t got);
            date_result_t want;
            if (pending_dates.size() == 0) begin
                $error("result with nothing pending: day_count_out %0d year_out %0d",
                       got.days, got.year);
                errors++;
                return;
            end
            want = pending_dates.pop_front();
            checked++;
            compare_field("day_count_out", want.days, got.days);
            compare_field("year_out", want.year, got.year);
            compare_field("month_out", want.month, got.month);
            compare_field("mday_out", want.mday, got.mday);
            compare_field("weekday_out", want.wday, got.wday);
            compare_field("range_error", want.range_err, got.range_err);
        endfunction

        function int unsigned outstanding();
            return pending_dates.size();
        endfunction

    endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top-level bench for epoch_day_date_converter_unit: directed and random conversions
// in both directions with random idling on both sides; depends on epdc_pkg, epdc_tb_pkg.
module tb;

    import epdc_pkg::*;
    import epdc_tb_pkg::*;

    localparam int NUM_RANDOM     = 1400;
    localparam int QUIET_TAIL     = 150;
    localparam int CALM_SPAN      = 120;
    localparam int HOLD_AT_RESULT = 300;
    localparam int HOLD_CYCLES    = 400;
    localparam int PAUSE_AT_ITEM  = 600;
    localparam int DRAIN_CYCLES   = 250;
    localparam int WATCHDOG_LIMIT = 3000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               func;
    logic [YEAR_W-1:0]  year_since_1900;
    logic [MONTH_W-1:0] month_index;
    logic [MDAY_W-1:0]  day_of_month;
    logic [DAYS_W-1:0]  day_count_in;
    logic               out_valid;
    logic               out_stall;
    logic [DAYS_W-1:0]  day_count_out;
    logic [YEAR_W-1:0]  year_out;
    logic [MONTH_W-1:0] month_out;
    logic [MDAY_W-1:0]  mday_out;
    logic [WDAY_W-1:0]  weekday_out;
    logic               range_error;

    calendar_scoreboard sb;
    bit                 quiet;

    epoch_day_date_converter_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .year_since_1900 (year_since_1900),
        .month_index     (month_index),
        .day_of_month    (day_of_month),
        .day_count_in    (day_count_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .day_count_out   (day_count_out),
        .year_out        (year_out),
        .month_out       (month_out),
        .mday_out        (mday_out),
        .weekday_out     (weekday_out),
        .range_error     (range_error)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic date_request_t make_request(logic f, int unsigned y, int unsigned m,
                                                   int unsigned d, int unsigned days);
        date_request_t rq;
        rq.func  = f;
        rq.year  = YEAR_W'(y);
        rq.month = MONTH_W'(m);
        rq.mday  = MDAY_W'(d);
        rq.days  = DAYS_W'(days);
        return rq;
    endfunction

    // mostly valid dates, some out-of-range years, month codes and day zero
    function automatic date_request_t random_request();
        date_request_t rq;
        rq.func  = 1'($urandom_range(0, 1));
        rq.year  = ($urandom_range(0, 9) == 0) ? YEAR_W'($urandom_range(0, 255))
                                               : YEAR_W'($urandom_range(LOWEST_YEAR,
                                                                        HIGHEST_YEAR));
        rq.month = ($urandom_range(0, 9) == 0) ? MONTH_W'($urandom_range(0, 15))
                                               : MONTH_W'($urandom_range(0, 11));
        rq.mday  = ($urandom_range(0, 9) == 0) ? MDAY_W'($urandom_range(0, 31))
                                               : MDAY_W'($urandom_range(1, 28));
        rq.days  = DAYS_W'($urandom_range(0, 65535));
        return rq;
    endfunction

    // offer one item and hold it until taken
    task automatic send_request(date_request_t rq);
        bit taken;
        taken = 1'b0;
        @(negedge clk);
        in_valid        <= 1'b1;
        func            <= rq.func;
        year_since_1900 <= rq.year;
        month_index     <= rq.month;
        day_of_month    <= rq.mday;
        day_count_in    <= rq.days;
        while (!taken)
        begin
            @(posedge clk);
            taken = !in_stall;
        end
        sb.note_request(rq);
    endtask

    task automatic pause_input(int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic wait_drained();
        pause_input(1);
        while (sb.outstanding() != 0) @(posedge clk);
    endtask

    // result side: check each taken item, stall in bursts, one long hold-off
    initial
    begin
        int unsigned  stall_left;
        bit           hold_done;
        date_result_t got;
        stall_left = 0;
        hold_done  = 1'b0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.days      = day_count_out;
                got.year      = year_out;
                got.month     = month_out;
                got.mday      = mday_out;
                got.wday      = weekday_out;
                got.range_err = range_error;
                sb.check_result(got);
            end
            @(negedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (!hold_done && sb.checked >= HOLD_AT_RESULT)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            else if (!quiet && (sb.checked / CALM_SPAN) % 4 != 3
                     && $urandom_range(0, 3) == 0)
                stall_left = $urandom_range(1, 19);
            out_stall <= (stall_left > 0);
        end
    end

    // watchdog on cycles with no item moving
    initial
    begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // stimulus
    initial
    begin
        int i;
        sb              = new();
        quiet           = 1'b0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        func            = FUNC_TO_DAYS;
        year_since_1900 = '0;
        month_index     = '0;
        day_of_month    = '0;
        day_count_in    = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: epoch, day zero wrap, year limits, month saturation, leap days, day counts to date
        send_request(make_request(FUNC_TO_DAYS, 70, 0, 1, 65535));
        send_request(make_request(FUNC_TO_DAYS, 70, 0, 0, 0));
        send_request(make_request(FUNC_TO_DAYS, 69, 5, 10, 0));
        send_request(make_request(FUNC_TO_DAYS, 200, 0, 1, 0));
        send_request(make_request(FUNC_TO_DAYS, 0, 0, 1, 0));
        send_request(make_request(FUNC_TO_DAYS, 255, 15, 31, 65535));
        send_request(make_request(FUNC_TO_DAYS, 199, 11, 31, 0));
        send_request(make_request(FUNC_TO_DAYS, 199, 15, 31, 0));
        send_request(make_request(FUNC_TO_DAYS, 130, 12, 1, 0));
        send_request(make_request(FUNC_TO_DAYS, 85, 13, 16, 0));
        send_request(make_request(FUNC_TO_DAYS, 72, 1, 29, 0));
        send_request(make_request(FUNC_TO_DAYS, 100, 2, 1, 0));
        send_request(make_request(FUNC_TO_DAYS, 150, 5, 31, 0));
        send_request(make_request(FUNC_TO_DAYS, 70, 11, 31, 0));
        send_request(make_request(FUNC_TO_DATE, 0, 0, 0, 0));
        send_request(make_request(FUNC_TO_DATE, 255, 15, 31, 65535));
        send_request(make_request(FUNC_TO_DATE, 70, 0, 1, 59));
        send_request(make_request(FUNC_TO_DATE, 70, 0, 1, 789));
        send_request(make_request(FUNC_TO_DATE, 70, 0, 1, 10957));
        send_request(make_request(FUNC_TO_DATE, 70, 0, 1, 47481));
        send_request(make_request(FUNC_TO_DATE, 70, 0, 1, 47540));
        send_request(make_request(FUNC_TO_DATE, 70, 0, 1, 47541));
        send_request(make_request(FUNC_TO_DATE, 70, 0, 1, 32767));

        // random conversions with idle bursts, calm spans and a quiet tail
        for (i = 0; i < NUM_RANDOM; i++)
        begin
            quiet = (i >= NUM_RANDOM - QUIET_TAIL);
            if (i == PAUSE_AT_ITEM)
                wait_drained();
            if (!quiet && (i / CALM_SPAN) % 4 != 3 && $urandom_range(0, 3) == 0)
                pause_input($urandom_range(1, 19));
            send_request(random_request());
        end

        // let the last results come out, then make sure nothing extra follows
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("tb: %0d results checked: %0d date to day count (%0d out-of-range years)",
                 sb.checked, sb.to_days, sb.bad_years);
        $display("tb: %0d day count to date, %0d mismatches", sb.to_date, sb.errors);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
